FILE: rtl/grst_pkg.sv
package grst_pkg;

	localparam logic [3:0] ACT_CLAIM    = 4'd0;
	localparam logic [3:0] ACT_RECORD   = 4'd1;
	localparam logic [3:0] ACT_FIND     = 4'd2;
	localparam logic [3:0] ACT_READ     = 4'd3;
	localparam logic [3:0] ACT_SET_LOAD = 4'd4;
	localparam logic [3:0] ACT_SET_KEY  = 4'd5;
	localparam logic [3:0] ACT_SET_ADDR = 4'd6;
	localparam logic [3:0] ACT_ADVANCE  = 4'd7;
	localparam logic [3:0] ACT_CLEAR    = 4'd8;

	localparam logic [1:0] CFG_RAM_BASE  = 2'd0;
	localparam logic [1:0] CFG_RAM_LIMIT = 2'd1;

	localparam logic [23:0] RAM_LIMIT_RESET = 24'd1048576;
	localparam logic [25:0] PTR_MAX         = 26'h1FFFFFC;

	// Command held stable and broadcast to every cell while a token walks.
	typedef struct packed {
		logic [3:0]  action;
		logic        kind;
		logic [5:0]  slot;
		logic [31:0] key;
		logic [23:0] addr;
		logic        lval;
	} cmd_t;

	// Token handed from cell to cell, gathering the outcome of the action.
	typedef struct packed {
		logic        valid;
		logic        hit;
		logic [5:0]  idx;
		logic [23:0] addr;
	} tok_t;

	typedef struct packed {
		logic [5:0]  slot;
		logic        found;
		logic [23:0] addr;
		logic        ovf;
		logic [24:0] ptr;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_HOLD
	} state_t;

endpackage

FILE: rtl/graphics_ram_slot_table_top.sv
// Slot table for a graphics memory: font slots first, then image slots.
// Input channel (in_valid/in_ready) carries one action item; output channel
// (out_valid/out_ready) returns exactly one result item for each of them.
// Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 writes ram_base and reloads the fill pointer, index 1
// writes ram_limit, other indexes are ignored. Write it only while idle.
// Each slot lives in a cell of a chain. An accepted item is held as a
// broadcast command and a token walks the chain one cell per cycle; the
// first matching cell of a region marks the token, so priority follows the
// chain order. An item passes from the command register through the cells
// to the hold register and then to the output register. One item is in
// work at a time; the next one is accepted as soon as its result has left
// the hold register, even while the output register waits.
// Reset clears every slot, sets ram_base to 0, ram_limit to 1048576 and
// the fill pointer to 0. A stalled receiver keeps the result in the output
// register; a following result waits in the hold register and no new item
// is accepted until it moves on.
module graphics_ram_slot_table_top #(
	parameter int FONT_SLOTS  = 8,
	parameter int IMAGE_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  action,
	input  logic        kind,
	input  logic [5:0]  slot,
	input  logic [31:0] source_key,
	input  logic [23:0] block_address,
	input  logic [23:0] block_size,
	input  logic        loaded_value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  slot_result,
	output logic        found,
	output logic [23:0] address_out,
	output logic        overflow,
	output logic [24:0] fill_pointer,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int N = FONT_SLOTS + IMAGE_SLOTS;

	grst_pkg::state_t state_q, state_n;
	grst_pkg::cmd_t   cmd_q;
	grst_pkg::tok_t   chain [N+1];
	grst_pkg::res_t   pend_q, out_q;
	logic [N:0]       tok_v;
	logic             start_q;
	logic             out_valid_q;
	logic [24:0]      pointer_q;
	logic [23:0]      limit_q;

	logic             accept;
	logic             pend_load;
	logic             out_load;
	logic             in_range;
	logic             do_advance;
	logic [25:0]      ptr_sum;
	logic [25:0]      ptr_aligned;
	logic [24:0]      ptr_next;
	logic             rec_hit;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			grst_pkg::ST_IDLE: if (in_valid) state_n = grst_pkg::ST_WALK;
			grst_pkg::ST_WALK: if (chain[N].valid) state_n = grst_pkg::ST_HOLD;
			grst_pkg::ST_HOLD: if (!out_valid_q || out_ready) state_n = grst_pkg::ST_IDLE;
			default: state_n = grst_pkg::ST_IDLE;
		endcase
	end

	// Controls decoded from the state.
	always_comb begin
		in_ready  = 1'b0;
		pend_load = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			grst_pkg::ST_IDLE: in_ready = 1'b1;
			grst_pkg::ST_WALK: pend_load = chain[N].valid;
			grst_pkg::ST_HOLD: out_load = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// The fill pointer moves at accept time, straight from the input fields.
	assign in_range   = ({1'b0, slot} < 7'(N));
	assign do_advance = (action == grst_pkg::ACT_ADVANCE) ||
	                    ((action == grst_pkg::ACT_RECORD) && in_range);
	assign ptr_sum     = {1'b0, pointer_q} + {2'b00, block_size} + 26'd3;
	assign ptr_aligned = {ptr_sum[25:2], 2'b00};
	assign ptr_next    = (ptr_aligned > grst_pkg::PTR_MAX) ?
	                     grst_pkg::PTR_MAX[24:0] : ptr_aligned[24:0];

	// A record that reached a real slot is the only one that reports overflow.
	assign rec_hit = (cmd_q.action == grst_pkg::ACT_RECORD) &&
	                 ({1'b0, cmd_q.slot} < 7'(N));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grst_pkg::ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pointer_q   <= '0;
			limit_q     <= grst_pkg::RAM_LIMIT_RESET;
		end else begin
			state_q <= state_n;
			start_q <= accept;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			priority if (accept) begin
				if (do_advance) pointer_q <= ptr_next;
			end else if (cfg_valid && (cfg_index == grst_pkg::CFG_RAM_BASE)) begin
				pointer_q <= {1'b0, cfg_data};
			end else begin
				pointer_q <= pointer_q;
			end
			if (cfg_valid && (cfg_index == grst_pkg::CFG_RAM_LIMIT)) begin
				limit_q <= cfg_data;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.action <= action;
			cmd_q.kind   <= kind;
			cmd_q.slot   <= slot;
			cmd_q.key    <= source_key;
			cmd_q.addr   <= block_address;
			cmd_q.lval   <= loaded_value;
		end
		if (pend_load) begin
			pend_q.slot  <= chain[N].idx;
			pend_q.found <= chain[N].hit;
			pend_q.addr  <= chain[N].addr;
			pend_q.ovf   <= rec_hit && (pointer_q > {1'b0, limit_q});
			pend_q.ptr   <= pointer_q;
		end
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	// The token enters the first cell the cycle after accept, empty.
	assign chain[0] = '{valid: start_q, hit: 1'b0, idx: 6'd0, addr: 24'd0};

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			grst_cell #(
				.IDX        (g),
				.FONT_SLOTS (FONT_SLOTS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd_q),
				.tok_in  (chain[g]),
				.tok_out (chain[g+1])
			);
		end
		for (g = 0; g <= N; g++) begin : g_tokv
			assign tok_v[g] = chain[g].valid;
		end
	endgenerate

	assign out_valid    = out_valid_q;
	assign slot_result  = out_q.slot;
	assign found        = out_q.found;
	assign address_out  = out_q.addr;
	assign overflow     = out_q.ovf;
	assign fill_pointer = out_q.ptr;

	// Only one token is ever in the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one token in the cell chain");

	// No token walks while the block is idle or holding a result.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != grst_pkg::ST_WALK) |-> (tok_v[N:1] == '0))
		else $error("token in the chain outside a walk");

	// An accepted item starts a walk and injects a token.
	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == grst_pkg::ST_WALK) && start_q)
		else $error("accepted item did not start a walk");

	// The command stays put while its token walks.
	a_cmd_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == grst_pkg::ST_WALK) && $past(state_q == grst_pkg::ST_WALK)
		|-> $stable(cmd_q))
		else $error("command changed during a walk");

endmodule

FILE: rtl/grst_cell.sv
module grst_cell #(
	parameter int IDX        = 0,
	parameter int FONT_SLOTS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  grst_pkg::cmd_t cmd,
	input  grst_pkg::tok_t tok_in,
	output grst_pkg::tok_t tok_out
);

	logic           loaded_q;
	logic [31:0]    key_q;
	logic [23:0]    addr_q;
	grst_pkg::tok_t tok_q;

	logic           loaded_n;
	logic [31:0]    key_n;
	logic [23:0]    addr_n;
	grst_pkg::tok_t tok_n;
	logic           in_region;
	logic           slot_hit;

	// Font slots sit below FONT_SLOTS, image slots from FONT_SLOTS up.
	assign in_region = cmd.kind ? (IDX < FONT_SLOTS) : (IDX >= FONT_SLOTS);
	assign slot_hit  = ({1'b0, cmd.slot} == 7'(IDX));

	always_comb begin
		tok_n    = tok_in;
		loaded_n = loaded_q;
		key_n    = key_q;
		addr_n   = addr_q;
		if (tok_in.valid) begin
			unique case (cmd.action)
				grst_pkg::ACT_CLAIM: begin
					if (in_region && !tok_in.hit && !loaded_q) begin
						loaded_n  = 1'b1;
						tok_n.hit = 1'b1;
						tok_n.idx = 6'(IDX);
					end
				end
				grst_pkg::ACT_FIND: begin
					if (in_region && !tok_in.hit && (key_q == cmd.key)) begin
						tok_n.hit = 1'b1;
						tok_n.idx = 6'(IDX);
					end
				end
				grst_pkg::ACT_RECORD: begin
					if (slot_hit) begin
						loaded_n = 1'b1;
						key_n    = cmd.key;
						addr_n   = cmd.addr;
					end
				end
				grst_pkg::ACT_READ: begin
					if (slot_hit) begin
						tok_n.addr = addr_q;
					end
				end
				grst_pkg::ACT_SET_LOAD: begin
					if (slot_hit) begin
						loaded_n = cmd.lval;
					end
				end
				grst_pkg::ACT_SET_KEY: begin
					if (slot_hit) begin
						key_n = cmd.key;
					end
				end
				grst_pkg::ACT_SET_ADDR: begin
					if (slot_hit) begin
						addr_n = cmd.addr;
					end
				end
				grst_pkg::ACT_CLEAR: begin
					loaded_n = 1'b0;
					key_n    = '0;
					addr_n   = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			key_q    <= '0;
			addr_q   <= '0;
			tok_q    <= '0;
		end else begin
			loaded_q <= loaded_n;
			key_q    <= key_n;
			addr_q   <= addr_n;
			tok_q    <= tok_n;
		end
	end

	assign tok_out = tok_q;

endmodule
